// ===== hdl/kmer_window_min_fingerprint_defines.svh =====
// Assertion macros shared by the fingerprint checker.
`ifndef KMER_WINDOW_MIN_FINGERPRINT_DEFINES_SVH
`define KMER_WINDOW_MIN_FINGERPRINT_DEFINES_SVH

// same-cycle implication, off during reset
`define KWMF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("kwmf check failed");

// next-cycle implication, off during reset
`define KWMF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("kwmf check failed");

// next-cycle implication, live during reset
`define KWMF_ASSERT_RST(label, ante, cons) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("kwmf reset check failed");

`endif

// ===== hdl/kwmf_pkg.sv =====
// Types and constants of the k-mer window minimum fingerprint block.
`default_nettype none
package kwmf_pkg;

    localparam logic        ACT_TOKEN       = 1'b0;
    localparam logic        ACT_RESTART     = 1'b1;
    localparam logic [7:0]  SPACE_CHAR      = 8'd32;
    localparam logic [31:0] DIGIT_BASE      = 32'd48;
    localparam logic [31:0] HASH_MAX_POS    = 32'h7FFF_FFFF;
    localparam logic [15:0] INDEX_MAX       = 16'hFFFF;

    localparam logic        CFG_KMER_LENGTH = 1'b0;
    localparam logic        CFG_WINDOW_SIZE = 1'b1;
    localparam logic [3:0]  KMER_RESET      = 4'd9;
    localparam logic [3:0]  WINDOW_RESET    = 4'd5;

    localparam int          QUEUE_DEPTH     = 4;

    typedef logic cfg_idx_t;

    typedef struct packed {
        logic        emit;
        logic [15:0] window_index;
    } job_ctrl_t;

endpackage
`default_nettype wire

// ===== hdl/kwmf_front.sv =====
// Front end: config registers, request classification, byte history and record counters.
`default_nettype none
module kwmf_front
    import kwmf_pkg::*;
#(
    parameter int KMER_MAX   = 9,
    parameter int WINDOW_MAX = 8,
    localparam int KW = $clog2(KMER_MAX + 1),
    localparam int WW = $clog2(WINDOW_MAX + 1)
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_wr_en,
    input  wire cfg_idx_t                 cfg_index,
    input  wire logic [3:0]               cfg_wdata,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic                     s_action,
    input  wire logic [7:0]               s_token_char,
    output logic                          job_push,
    input  wire logic                     job_full,
    output logic [KMER_MAX-1:0][7:0]      job_bytes,
    output logic [KW-1:0]                 job_k,
    output logic [WW-1:0]                 job_w,
    output job_ctrl_t                     job_ctrl
);

    logic [3:0]               kmer_length_reg;
    logic [3:0]               window_size_reg;
    logic [KMER_MAX-1:0][7:0] hist_reg, hist_next;
    logic [KW-1:0]            bytes_seen_reg, bytes_seen_next;
    logic [WW-1:0]            hashes_seen_reg, hashes_seen_next;
    logic [15:0]              win_cnt_reg, win_cnt_next;

    logic [5:0]    k_raw, w_raw;
    logic [KW-1:0] k_eff, bytes_inc;
    logic [WW-1:0] w_eff, hashes_inc;
    logic          accept, kept, make_hash, emit;

    assign k_raw = {2'b00, kmer_length_reg};
    assign w_raw = {2'b00, window_size_reg};

    always_comb begin
        if (k_raw == 6'd0) begin
            k_eff = KW'(1);
        end else if (k_raw > 6'(KMER_MAX)) begin
            k_eff = KW'(KMER_MAX);
        end else begin
            k_eff = k_raw[KW-1:0];
        end
        if (w_raw == 6'd0) begin
            w_eff = WW'(1);
        end else if (w_raw > 6'(WINDOW_MAX)) begin
            w_eff = WW'(WINDOW_MAX);
        end else begin
            w_eff = w_raw[WW-1:0];
        end
    end

    assign s_ready    = !job_full;
    assign accept     = s_valid && s_ready;
    assign kept       = accept && (s_action == ACT_TOKEN) && (s_token_char != SPACE_CHAR);
    assign bytes_inc  = (bytes_seen_reg == KW'(KMER_MAX)) ? bytes_seen_reg
                                                          : bytes_seen_reg + KW'(1);
    assign hashes_inc = (hashes_seen_reg == WW'(WINDOW_MAX)) ? hashes_seen_reg
                                                             : hashes_seen_reg + WW'(1);
    assign make_hash  = kept && (bytes_inc >= k_eff);
    assign emit       = make_hash && (hashes_inc >= w_eff);

    always_comb begin
        hist_next        = hist_reg;
        bytes_seen_next  = bytes_seen_reg;
        hashes_seen_next = hashes_seen_reg;
        win_cnt_next     = win_cnt_reg;
        if (accept && (s_action == ACT_RESTART)) begin
            bytes_seen_next  = '0;
            hashes_seen_next = '0;
            win_cnt_next     = '0;
        end else if (kept) begin
            hist_next       = (KMER_MAX * 8)'({hist_reg, s_token_char});
            bytes_seen_next = bytes_inc;
            if (make_hash) begin
                hashes_seen_next = hashes_inc;
            end
            if (emit && (win_cnt_reg != INDEX_MAX)) begin
                win_cnt_next = win_cnt_reg + 16'd1;
            end
        end
    end

    assign job_push              = make_hash;
    assign job_bytes             = hist_next;
    assign job_k                 = k_eff;
    assign job_w                 = w_eff;
    assign job_ctrl.emit         = emit;
    assign job_ctrl.window_index = win_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kmer_length_reg <= KMER_RESET;
            window_size_reg <= WINDOW_RESET;
            bytes_seen_reg  <= '0;
            hashes_seen_reg <= '0;
            win_cnt_reg     <= '0;
        end else begin
            if (cfg_wr_en && (cfg_index == CFG_KMER_LENGTH)) begin
                kmer_length_reg <= cfg_wdata;
            end
            if (cfg_wr_en && (cfg_index == CFG_WINDOW_SIZE)) begin
                window_size_reg <= cfg_wdata;
            end
            bytes_seen_reg  <= bytes_seen_next;
            hashes_seen_reg <= hashes_seen_next;
            win_cnt_reg     <= win_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        hist_reg <= hist_next;
    end

endmodule
`default_nettype wire

// ===== hdl/kwmf_queue.sv =====
// Small first-in first-out queue of hash jobs between front and back end.
`default_nettype none
module kwmf_queue
    import kwmf_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] din,
    output logic                  full,
    input  wire logic             pop,
    output logic                  not_empty,
    output logic [WIDTH-1:0]      dout
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push, do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign dout      = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule
`default_nettype wire

// ===== hdl/kwmf_back.sv =====
// Back end: digit-per-stage hash pipeline, hash window, minimum tree and output register.
`default_nettype none
module kwmf_back
    import kwmf_pkg::*;
#(
    parameter int KMER_MAX   = 9,
    parameter int WINDOW_MAX = 8,
    localparam int KW = $clog2(KMER_MAX + 1),
    localparam int WW = $clog2(WINDOW_MAX + 1),
    localparam int TL = $clog2(WINDOW_MAX),
    localparam int TP = 1 << TL
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     job_valid,
    output logic                          job_pop,
    input  wire logic [KMER_MAX-1:0][7:0] job_bytes,
    input  wire logic [KW-1:0]            job_k,
    input  wire logic [WW-1:0]            job_w,
    input  wire job_ctrl_t                job_ctrl,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic signed [31:0]            m_fingerprint,
    output logic [15:0]                   m_window_index
);

    logic                     adv;
    logic                     hv_reg [KMER_MAX];
    logic [31:0]              hh_reg [KMER_MAX];
    logic [KMER_MAX-1:0][7:0] hb_reg [KMER_MAX];
    logic [KW-1:0]            hk_reg [KMER_MAX];
    logic [WW-1:0]            hw_reg [KMER_MAX];
    job_ctrl_t                hc_reg [KMER_MAX];
    logic [31:0]              h_next [KMER_MAX];

    logic signed [31:0]       win_reg [WINDOW_MAX];
    logic signed [31:0]       cand_next [TP];
    logic signed [31:0]       tr_reg [TL+1][TP];
    logic                     tv_reg [TL+1];
    job_ctrl_t                tc_reg [TL+1];

    logic                     m_valid_reg;
    logic signed [31:0]       m_fp_reg;
    logic [15:0]              m_idx_reg;

    function automatic logic signed [31:0] smin(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        return (a < b) ? a : b;
    endfunction

    assign adv     = !m_valid_reg || m_ready;
    assign job_pop = adv && job_valid;

    always_comb begin
        logic [31:0]              hin;
        logic [KMER_MAX-1:0][7:0] bin;
        logic [KW-1:0]            kin;
        for (int s = 0; s < KMER_MAX; s++) begin
            if (s == 0) begin
                hin = '0;
                bin = job_bytes;
                kin = job_k;
            end else begin
                hin = hh_reg[s-1];
                bin = hb_reg[s-1];
                kin = hk_reg[s-1];
            end
            if ((KMER_MAX - 1 - s) < int'(kin)) begin
                h_next[s] = hin * 32'd10 + {24'd0, bin[KMER_MAX-1-s]} - DIGIT_BASE;
            end else begin
                h_next[s] = hin;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < TP; i++) begin
            cand_next[i] = HASH_MAX_POS;
        end
        cand_next[0] = hh_reg[KMER_MAX-1];
        for (int i = 1; i < TP; i++) begin
            if ((i < WINDOW_MAX) && (i < int'(hw_reg[KMER_MAX-1]))) begin
                cand_next[i] = win_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < KMER_MAX; s++) begin
                hv_reg[s] <= 1'b0;
            end
            for (int l = 0; l <= TL; l++) begin
                tv_reg[l] <= 1'b0;
            end
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            hv_reg[0] <= job_valid;
            for (int s = 1; s < KMER_MAX; s++) begin
                hv_reg[s] <= hv_reg[s-1];
            end
            tv_reg[0] <= hv_reg[KMER_MAX-1];
            for (int l = 1; l <= TL; l++) begin
                tv_reg[l] <= tv_reg[l-1];
            end
            m_valid_reg <= tv_reg[TL] && tc_reg[TL].emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            hh_reg[0] <= h_next[0];
            hb_reg[0] <= job_bytes;
            hk_reg[0] <= job_k;
            hw_reg[0] <= job_w;
            hc_reg[0] <= job_ctrl;
            for (int s = 1; s < KMER_MAX; s++) begin
                hh_reg[s] <= h_next[s];
                hb_reg[s] <= hb_reg[s-1];
                hk_reg[s] <= hk_reg[s-1];
                hw_reg[s] <= hw_reg[s-1];
                hc_reg[s] <= hc_reg[s-1];
            end
            if (hv_reg[KMER_MAX-1]) begin
                win_reg[0] <= hh_reg[KMER_MAX-1];
                for (int i = 1; i < WINDOW_MAX; i++) begin
                    win_reg[i] <= win_reg[i-1];
                end
            end
            for (int i = 0; i < TP; i++) begin
                tr_reg[0][i] <= cand_next[i];
            end
            tc_reg[0] <= hc_reg[KMER_MAX-1];
            for (int l = 1; l <= TL; l++) begin
                for (int j = 0; j < (TP >> l); j++) begin
                    tr_reg[l][j] <= smin(tr_reg[l-1][2*j], tr_reg[l-1][2*j+1]);
                end
                tc_reg[l] <= tc_reg[l-1];
            end
            if (tv_reg[TL] && tc_reg[TL].emit) begin
                m_fp_reg  <= tr_reg[TL][0];
                m_idx_reg <= tc_reg[TL].window_index;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_fingerprint  = m_fp_reg;
    assign m_window_index = m_idx_reg;

endmodule
`default_nettype wire

// ===== hdl/kmer_window_min_fingerprint.sv =====
// Top level of the k-mer window minimum fingerprint block.
// Takes one token byte request per cycle and sustains one per cycle as long as
// the result side takes its requests. A kept byte that completes a k-mer leaves
// the front end as a hash job in a four-entry queue; the back end forms the
// decimal hash one digit per pipeline stage (KMER_MAX stages), shifts it into
// the hash window and reduces the window through a registered minimum tree of
// clog2(WINDOW_MAX) levels and presents the minimum from the output register.
// Restart, space and short-record requests produce no result.
// Register 0 is kmer_length, register 1 is window_size; write them while idle.
`default_nettype none
module kmer_window_min_fingerprint
    import kwmf_pkg::*;
#(
    parameter int KMER_MAX   = 9,
    parameter int WINDOW_MAX = 8
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire cfg_idx_t           cfg_index,
    input  wire logic [3:0]         cfg_wdata,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_action,
    input  wire logic [7:0]         s_token_char,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_fingerprint,
    output logic [15:0]             m_window_index
);

    localparam int KW    = $clog2(KMER_MAX + 1);
    localparam int WW    = $clog2(WINDOW_MAX + 1);
    localparam int JOB_W = KMER_MAX * 8 + KW + WW + $bits(job_ctrl_t);

    logic                     f_push, q_full, q_not_empty, b_pop;
    logic [KMER_MAX-1:0][7:0] f_bytes, b_bytes;
    logic [KW-1:0]            f_k, b_k;
    logic [WW-1:0]            f_w, b_w;
    job_ctrl_t                f_ctrl, b_ctrl;
    logic [JOB_W-1:0]         q_din, q_dout;

    kwmf_front #(
        .KMER_MAX   (KMER_MAX),
        .WINDOW_MAX (WINDOW_MAX)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_token_char (s_token_char),
        .job_push     (f_push),
        .job_full     (q_full),
        .job_bytes    (f_bytes),
        .job_k        (f_k),
        .job_w        (f_w),
        .job_ctrl     (f_ctrl)
    );

    assign q_din = {f_ctrl, f_w, f_k, f_bytes};

    kwmf_queue #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (f_push),
        .din       (q_din),
        .full      (q_full),
        .pop       (b_pop),
        .not_empty (q_not_empty),
        .dout      (q_dout)
    );

    assign {b_ctrl, b_w, b_k, b_bytes} = q_dout;

    kwmf_back #(
        .KMER_MAX   (KMER_MAX),
        .WINDOW_MAX (WINDOW_MAX)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .job_valid      (q_not_empty),
        .job_pop        (b_pop),
        .job_bytes      (b_bytes),
        .job_k          (b_k),
        .job_w          (b_w),
        .job_ctrl       (b_ctrl),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_fingerprint  (m_fingerprint),
        .m_window_index (m_window_index)
    );

endmodule
`default_nettype wire

// ===== hdl/kwmf_checker.sv =====
// Port-level checker of the fingerprint block and its bind to the top level.
`default_nettype none
`include "kmer_window_min_fingerprint_defines.svh"
module kwmf_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [31:0] m_fingerprint,
    input  wire logic [15:0] m_window_index
);

    logic        in_seen_reg, in_seen_next;
    logic        out_seen_reg, out_seen_next;
    logic [15:0] last_idx_reg, last_idx_next;
    logic [47:0] m_payload;
    logic        idx_ok;

    always_comb begin
        in_seen_next  = in_seen_reg || (s_valid && s_ready);
        out_seen_next = out_seen_reg || (m_valid && m_ready);
        last_idx_next = (m_valid && m_ready) ? m_window_index : last_idx_reg;
        m_payload     = {m_fingerprint, m_window_index};
        idx_ok        = (m_window_index == last_idx_reg + 16'd1) ||
                        (m_window_index == 16'd0) ||
                        ((last_idx_reg == 16'hFFFF) && (m_window_index == 16'hFFFF));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_seen_reg  <= 1'b0;
            out_seen_reg <= 1'b0;
            last_idx_reg <= '0;
        end else begin
            in_seen_reg  <= in_seen_next;
            out_seen_reg <= out_seen_next;
            last_idx_reg <= last_idx_next;
        end
    end

    `KWMF_ASSERT_RST(a_reset_state, !aresetn, !m_valid && s_ready)
    `KWMF_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_payload))
    `KWMF_ASSERT_NOW(a_out_after_in, m_valid, in_seen_reg)
    `KWMF_ASSERT_NOW(a_index_step, out_seen_reg && m_valid && m_ready, idx_ok)

endmodule

bind kmer_window_min_fingerprint kwmf_checker u_kwmf_checker (.*);
`default_nettype wire

// ===== bench/tb_kmer_window_min_fingerprint.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the k-mer window minimum fingerprint block.
module tb_kmer_window_min_fingerprint;
    import kwmf_pkg::*;

    localparam int         KMER_MAX      = 9;
    localparam int         WINDOW_MAX    = 8;
    localparam int         SETTLE_CYCLES = 40;
    localparam logic [7:0] DIGIT_ZERO    = DIGIT_BASE[7:0];

    typedef struct {
        logic signed [31:0] fingerprint;
        logic [15:0]        window_index;
    } fp_result_t;

    logic               aclk           = 1'b0;
    logic               aresetn        = 1'b0;
    logic               cfg_wr_en      = 1'b0;
    cfg_idx_t           cfg_index      = CFG_KMER_LENGTH;
    logic [3:0]         cfg_wdata      = 4'd0;
    logic               s_valid        = 1'b0;
    logic               s_ready;
    logic               s_action       = ACT_TOKEN;
    logic [7:0]         s_token_char   = 8'd0;
    logic               m_valid;
    logic               m_ready        = 1'b0;
    logic signed [31:0] m_fingerprint;
    logic [15:0]        m_window_index;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned fail_count    = 0;

    logic [3:0]  kmer_len_reg = KMER_RESET;
    logic [3:0]  win_size_reg = WINDOW_RESET;
    logic [7:0]  byte_hist [KMER_MAX];
    logic [31:0] hash_win [WINDOW_MAX];
    int unsigned kept_bytes;
    int unsigned kept_hashes;
    int unsigned window_count;
    fp_result_t  fp_pending [$];

    kmer_window_min_fingerprint #(
        .KMER_MAX   (KMER_MAX),
        .WINDOW_MAX (WINDOW_MAX)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_token_char   (s_token_char),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_fingerprint  (m_fingerprint),
        .m_window_index (m_window_index)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("tb_kmer_window_min_fingerprint failed");
        $finish;
    end

    function automatic void clear_record();
        int i;
        for (i = 0; i < KMER_MAX; i++) byte_hist[i] = 8'd0;
        for (i = 0; i < WINDOW_MAX; i++) hash_win[i] = 32'd0;
        kept_bytes   = 0;
        kept_hashes  = 0;
        window_count = 0;
    endfunction

    function automatic void winnow_step(input logic act, input logic [7:0] ch);
        int unsigned k;
        int unsigned w;
        int          i;
        logic [31:0] h;
        logic [31:0] m;
        fp_result_t  r;
        k = (kmer_len_reg == 4'd0) ? 1 :
            (kmer_len_reg > KMER_MAX) ? KMER_MAX : kmer_len_reg;
        w = (win_size_reg == 4'd0) ? 1 :
            (win_size_reg > WINDOW_MAX) ? WINDOW_MAX : win_size_reg;
        if (act == ACT_RESTART) begin
            clear_record();
            return;
        end
        if (ch == SPACE_CHAR) return;
        for (i = KMER_MAX - 1; i > 0; i--) byte_hist[i] = byte_hist[i - 1];
        byte_hist[0] = ch;
        if (kept_bytes < KMER_MAX) kept_bytes++;
        if (kept_bytes < k) return;
        h = 32'd0;
        for (i = k; i > 0; i--) h = h * 32'd10 + {24'd0, byte_hist[i - 1]} - DIGIT_BASE;
        for (i = WINDOW_MAX - 1; i > 0; i--) hash_win[i] = hash_win[i - 1];
        hash_win[0] = h;
        if (kept_hashes < WINDOW_MAX) kept_hashes++;
        if (kept_hashes < w) return;
        m = hash_win[0];
        for (i = 1; i < w; i++) begin
            if ($signed(hash_win[i]) < $signed(m)) m = hash_win[i];
        end
        r.fingerprint  = $signed(m);
        r.window_index = 16'(window_count);
        fp_pending.insert(fp_pending.size(), r);
        if (window_count < 65535) window_count++;
    endfunction

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        fp_result_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (fp_pending.size() == 0) begin
                $error("unexpected result: fingerprint %0d, window_index %0d",
                       m_fingerprint, m_window_index);
                fail_count++;
            end else begin
                exp_r = fp_pending.pop_front();
                if (m_fingerprint !== exp_r.fingerprint) begin
                    $error("fingerprint: expected %0d, got %0d",
                           exp_r.fingerprint, m_fingerprint);
                    fail_count++;
                end
                if (m_window_index !== exp_r.window_index) begin
                    $error("window_index: expected %0d, got %0d",
                           exp_r.window_index, m_window_index);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_request(input logic act, input logic [7:0] ch);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_action     <= act;
        s_token_char <= ch;
        do @(posedge aclk); while (!s_ready);
        winnow_step(act, ch);
    endtask

    task automatic send_text(input string text);
        int i;
        for (i = 0; i < text.len(); i++) send_request(ACT_TOKEN, text[i]);
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (fp_pending.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_window_params(input logic [3:0] k, input logic [3:0] w);
        wait_idle();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_KMER_LENGTH;
        cfg_wdata <= k;
        @(negedge aclk);
        cfg_index <= CFG_WINDOW_SIZE;
        cfg_wdata <= w;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        kmer_len_reg = k;
        win_size_reg = w;
    endtask

    task automatic test_default_registers();
        send_text("98765432 101234");
    endtask

    task automatic test_byte_extremes();
        set_window_params(4'd1, 4'd1);
        send_request(ACT_TOKEN, 8'h00);
        send_request(ACT_TOKEN, 8'hFF);
        send_request(ACT_TOKEN, SPACE_CHAR);
        send_request(ACT_RESTART, 8'hFF);
        send_request(ACT_TOKEN, DIGIT_ZERO + 8'd9);
        send_request(ACT_RESTART, 8'h00);
        send_request(ACT_TOKEN, DIGIT_ZERO);
    endtask

    task automatic test_register_clamp();
        set_window_params(4'd0, 4'd0);
        send_text("50");
    endtask

    task automatic test_random_records(input int unsigned n_items,
                                       input logic [3:0] k0, input logic [3:0] w0);
        int unsigned sent;
        int unsigned len;
        int unsigned roll;
        logic [7:0]  ch;
        logic [3:0]  kv;
        logic [3:0]  wv;
        sent = 0;
        set_window_params(k0, w0);
        while (sent < n_items) begin
            if ($urandom_range(2) == 0) begin
                kv = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(9, 1));
                wv = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8, 1));
                set_window_params(kv, wv);
            end
            if ($urandom_range(3) != 0) send_request(ACT_RESTART, 8'($urandom));
            len = $urandom_range(40);
            repeat (len) begin
                roll = $urandom_range(99);
                if (roll < 80) ch = DIGIT_ZERO + 8'($urandom_range(9));
                else if (roll < 88) ch = SPACE_CHAR;
                else ch = 8'($urandom);
                send_request(ACT_TOKEN, ch);
                if (ch != SPACE_CHAR) sent++;
            end
        end
    endtask

    initial begin
        clear_record();
        send_idle_pct = 25;
        recv_idle_pct = 73;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_default_registers();
        test_byte_extremes();
        test_register_clamp();
        test_random_records(400, 4'd9, 4'd8);

        send_idle_pct = 73;
        recv_idle_pct = 25;
        test_random_records(400, 4'd1, 4'd1);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_records(400, 4'd15, 4'd15);

        wait_idle();
        if (fail_count == 0) begin
            $display("tb_kmer_window_min_fingerprint passed");
        end else begin
            $display("tb_kmer_window_min_fingerprint failed");
        end
        $finish;
    end

endmodule
